// ===== sv/cursor_linked_list_engine_defines.svh =====
// Assertion macros for the cursor linked list engine.
`ifndef CURSOR_LINKED_LIST_ENGINE_DEFINES_SVH
`define CURSOR_LINKED_LIST_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CLE_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("cle: invariant violated");
`define CLE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cle: same-cycle implication violated");
`define CLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cle: next-cycle implication violated");
`else
`define CLE_ASSERT_ALWAYS(label, expr)
`define CLE_ASSERT_SAME(label, ante, cons)
`define CLE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/cle_pkg.sv =====
// Shared constants, types and functions of the cursor linked list engine.
package cle_pkg;

    localparam int NODES  = 16;
    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(NODES + 1);
    localparam int POS_W  = 5;
    localparam int ACT_W  = 2;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 4;
    localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [NODE_W-1:0] FREE_HEAD = NODE_W'(0);
    localparam logic [NODE_W-1:0] USED_HEAD = NODE_W'(NODES - 1);

    localparam logic [ACT_W-1:0] ACT_INSERT = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_DELETE = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_QUERY  = ACT_W'(2);

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
    } t_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             status;
        logic [LEN_W-1:0] length;
    } t_rsp;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] addr;
    } t_dwr;

    // Link value of an entry that has not been written since reset.
    function automatic logic [NODE_W-1:0] link_reset(input logic [NODE_W-1:0] idx);
        logic [NODE_W-1:0] val;
        if (int'(idx) < NODES - 2) begin
            val = idx + NODE_W'(1);
        end else begin
            val = '0;
        end
        return val;
    endfunction

endpackage

// ===== sv/cursor_linked_list_engine.sv =====
// Top level of the cursor linked list engine: handshakes, data store, result register.
//
//  channel | direction | handshake                    | fields
//  --------+-----------+------------------------------+------------------------------------
//  in      | to block  | i_in_valid / o_in_stall      | i_action, i_position, i_element_id
//  out     | from block| o_out_valid / i_out_stall    | o_status, o_list_length
//
// The single read port of the link store sets the pace of an item: the list is
// counted one link per cycle, then walked to the position one link per cycle;
// a length query stops after the count.
// Reset is synchronous; the link store comes up as its initial chains at once.
// The next item is taken while a result waits in the output register; a stalled
// output holds the finished walk in its done state until the register frees.
`include "cursor_linked_list_engine_defines.svh"

module cursor_linked_list_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [cle_pkg::ACT_W-1:0]        i_action,
    input  logic [cle_pkg::POS_W-1:0]        i_position,
    input  logic signed [cle_pkg::DATA_W-1:0] i_element_id,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_status,
    output logic [cle_pkg::LEN_W-1:0]        o_list_length
);

    cle_pkg::t_req req;
    cle_pkg::t_rsp rsp;
    cle_pkg::t_dwr dwr;

    logic                        in_acc;
    logic                        out_free;
    logic [cle_pkg::DATA_W-1:0]  r_word;
    logic                        r_out_valid;
    logic                        r_status;
    logic [cle_pkg::LEN_W-1:0]   r_len;

    assign in_acc       = i_in_valid && !rsp.busy;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign req.valid    = i_in_valid;
    assign req.action   = i_action;
    assign req.position = i_position;

    cle_walk u_walk (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .i_ack  (out_free),
        .o_rsp  (rsp),
        .o_dwr  (dwr)
    );

    // The data store is only ever written; its read port is left idle.
    cle_ram #(
        .WIDTH(cle_pkg::DATA_W),
        .DEPTH(cle_pkg::NODES)
    ) u_data_ram (
        .i_clk  (i_clk),
        .i_we   (dwr.we),
        .i_waddr(dwr.addr),
        .i_wdata(r_word),
        .i_raddr(cle_pkg::FREE_HEAD),
        .o_rdata()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp.done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (in_acc) begin
            r_word <= i_element_id;
        end
        if (rsp.done && out_free) begin
            r_status <= rsp.status;
            r_len    <= rsp.length;
        end
    end

    assign o_in_stall    = rsp.busy;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_list_length = r_len;

    `CLE_ASSERT_SAME(a_len_bound, o_out_valid, int'(o_list_length) <= cle_pkg::NODES - 2)
    `CLE_ASSERT_NEXT(a_accept_busy, in_acc, o_in_stall)
    `CLE_ASSERT_SAME(a_result_from_walk, $rose(o_out_valid), $past(rsp.done))

endmodule

// ===== sv/cle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/cle_walk.sv =====
// Sequencer that walks and relinks the link store, one link read per cycle.
module cle_walk (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cle_pkg::t_req i_req,
    input  logic          i_ack,
    output cle_pkg::t_rsp o_rsp,
    output cle_pkg::t_dwr o_dwr
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_COUNT,
        S_FRESH,
        S_FNEXT,
        S_WALK,
        S_ILINK,
        S_DGONE,
        S_DFREE,
        S_DHEAD,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [cle_pkg::ACT_W-1:0]  r_act, n_act;
    logic [cle_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [cle_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [cle_pkg::CNT_W-1:0]  r_k, n_k;
    logic [cle_pkg::CNT_W-1:0]  r_len, n_len;
    logic [cle_pkg::NODE_W-1:0] r_cur, n_cur;
    logic [cle_pkg::NODE_W-1:0] r_fresh, n_fresh;
    logic [cle_pkg::NODE_W-1:0] r_prev, n_prev;
    logic [cle_pkg::NODE_W-1:0] r_gone, n_gone;
    logic                       r_status, n_status;

    logic [cle_pkg::NODES-1:0]  r_vld;
    logic                       r_rvld;
    logic [cle_pkg::NODE_W-1:0] r_raddr;

    logic [cle_pkg::NODE_W-1:0] rd_addr;
    logic                       wr_en;
    logic [cle_pkg::NODE_W-1:0] wr_addr;
    logic [cle_pkg::NODE_W-1:0] wr_data;
    logic [cle_pkg::NODE_W-1:0] ram_q;
    logic [cle_pkg::NODE_W-1:0] lv;
    logic                       dwe;
    logic [cle_pkg::CMP_W-1:0]  pos_ext;
    logic [cle_pkg::CMP_W-1:0]  cnt_ext;

    cle_ram #(
        .WIDTH(cle_pkg::NODE_W),
        .DEPTH(cle_pkg::NODES)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    // An entry never written since reset reads as its initial link.
    assign lv      = r_rvld ? ram_q : cle_pkg::link_reset(r_raddr);
    assign pos_ext = cle_pkg::CMP_W'(r_pos);
    assign cnt_ext = cle_pkg::CMP_W'(r_cnt);

    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_len    = r_len;
        n_cur    = r_cur;
        n_fresh  = r_fresh;
        n_prev   = r_prev;
        n_gone   = r_gone;
        n_status = r_status;
        rd_addr  = r_raddr;
        wr_en    = 1'b0;
        wr_addr  = r_fresh;
        wr_data  = lv;
        dwe      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_act   = i_req.action;
                    n_pos   = i_req.position;
                    n_cnt   = '0;
                    rd_addr = cle_pkg::USED_HEAD;
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                if (lv != '0 && r_cnt < cle_pkg::CNT_W'(cle_pkg::NODES)) begin
                    n_cnt   = r_cnt + cle_pkg::CNT_W'(1);
                    rd_addr = lv;
                end else begin
                    // The list has been counted; decide what the action needs next.
                    n_len    = r_cnt;
                    n_status = cle_pkg::STATUS_ERR;
                    n_state  = S_DONE;
                    case (r_act)
                        cle_pkg::ACT_INSERT: begin
                            if (r_pos != '0 && pos_ext <= cnt_ext + cle_pkg::CMP_W'(1)) begin
                                rd_addr = cle_pkg::FREE_HEAD;
                                n_state = S_FRESH;
                            end
                        end
                        cle_pkg::ACT_DELETE: begin
                            if (r_pos != '0 && pos_ext <= cnt_ext) begin
                                rd_addr = cle_pkg::USED_HEAD;
                                n_cur   = cle_pkg::USED_HEAD;
                                n_k     = cle_pkg::CNT_W'(r_pos) - cle_pkg::CNT_W'(1);
                                n_state = S_WALK;
                            end
                        end
                        cle_pkg::ACT_QUERY: begin
                            n_status = cle_pkg::STATUS_OK;
                        end
                        default: begin
                            n_status = cle_pkg::STATUS_ERR;
                        end
                    endcase
                end
            end
            S_FRESH: begin
                if (lv == '0) begin
                    n_status = cle_pkg::STATUS_ERR;
                    n_state  = S_DONE;
                end else begin
                    n_fresh = lv;
                    rd_addr = lv;
                    n_state = S_FNEXT;
                end
            end
            S_FNEXT: begin
                // Unhook the fresh node from the free chain and store its word.
                wr_en   = 1'b1;
                wr_addr = cle_pkg::FREE_HEAD;
                wr_data = lv;
                dwe     = 1'b1;
                rd_addr = cle_pkg::USED_HEAD;
                n_cur   = cle_pkg::USED_HEAD;
                n_k     = cle_pkg::CNT_W'(r_pos) - cle_pkg::CNT_W'(1);
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_k != '0) begin
                    n_cur   = lv;
                    n_k     = r_k - cle_pkg::CNT_W'(1);
                    rd_addr = lv;
                end else begin
                    n_prev = r_cur;
                    if (r_act == cle_pkg::ACT_INSERT) begin
                        wr_en   = 1'b1;
                        wr_addr = r_fresh;
                        wr_data = lv;
                        n_state = S_ILINK;
                    end else if (lv == '0) begin
                        n_status = cle_pkg::STATUS_ERR;
                        n_state  = S_DONE;
                    end else begin
                        n_gone  = lv;
                        rd_addr = lv;
                        n_state = S_DGONE;
                    end
                end
            end
            S_ILINK: begin
                wr_en    = 1'b1;
                wr_addr  = r_prev;
                wr_data  = r_fresh;
                n_status = cle_pkg::STATUS_OK;
                n_len    = r_len + cle_pkg::CNT_W'(1);
                n_state  = S_DONE;
            end
            S_DGONE: begin
                wr_en   = 1'b1;
                wr_addr = r_prev;
                wr_data = lv;
                rd_addr = cle_pkg::FREE_HEAD;
                n_state = S_DFREE;
            end
            S_DFREE: begin
                wr_en   = 1'b1;
                wr_addr = r_gone;
                wr_data = lv;
                n_state = S_DHEAD;
            end
            S_DHEAD: begin
                wr_en    = 1'b1;
                wr_addr  = cle_pkg::FREE_HEAD;
                wr_data  = r_gone;
                n_status = cle_pkg::STATUS_OK;
                n_len    = r_len - cle_pkg::CNT_W'(1);
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_rvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_rvld <= r_vld[rd_addr];
        end
        r_act    <= n_act;
        r_pos    <= n_pos;
        r_cnt    <= n_cnt;
        r_k      <= n_k;
        r_len    <= n_len;
        r_cur    <= n_cur;
        r_fresh  <= n_fresh;
        r_prev   <= n_prev;
        r_gone   <= n_gone;
        r_status <= n_status;
        r_raddr  <= rd_addr;
    end

    assign o_rsp.busy   = (r_state != S_IDLE);
    assign o_rsp.done   = (r_state == S_DONE);
    assign o_rsp.status = r_status;
    assign o_rsp.length = r_len[cle_pkg::LEN_W-1:0];
    assign o_dwr.we     = dwe;
    assign o_dwr.addr   = r_fresh;

endmodule
